/* design/hbr_pkg.sv */
// shared types and constants for the hue-band pixel recolor pipeline
// band table, sector codes, register indexes; no dependencies
package hbr_pkg;

  localparam int unsigned NUM_BANDS = 7;
  localparam int unsigned BAND_W    = 3;

  // register indexes on the configuration port (word address)
  localparam logic [1:0] REG_LOW_SAT     = 2'd0;
  localparam logic [1:0] REG_BLUE_LIFT   = 2'd1;
  localparam logic [1:0] REG_BLUE_MARGIN = 2'd2;

  typedef enum logic [1:0] {
    MAX_RED,
    MAX_GREEN,
    MAX_BLUE
  } max_sel_t;

  // which channels carry full, x and m for the target hue
  typedef enum logic [1:0] {
    SECT_RG,  // r = full, g = x, b = m
    SECT_GB,  // r = m, g = full, b = x
    SECT_RB   // r = full, g = m, b = x
  } sector_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       changed;
  } pix_t;

  typedef struct packed {
    logic [6:0] low_sat_percent;
    logic [7:0] blue_lift;
    logic [7:0] blue_margin;
  } cfg_t;

  // open degree bands and their target coefficients
  localparam int unsigned BAND_LO [NUM_BANDS] = '{0, 330, 30, 50, 80, 180, 260};
  localparam int unsigned BAND_HI [NUM_BANDS] = '{30, 360, 50, 80, 180, 260, 330};
  localparam int unsigned BAND_XF [NUM_BANDS] = '{5, 5, 22, 43, 30, 40, 50};
  localparam int unsigned BAND_SV [NUM_BANDS] = '{3600, 3600, 4100, 4250, 2600, 2520, 2625};
  localparam int unsigned BAND_VM [NUM_BANDS] = '{80, 80, 82, 85, 65, 72, 75};
  localparam sector_t BAND_SECTOR [NUM_BANDS] =
    '{SECT_RB, SECT_RB, SECT_RG, SECT_RG, SECT_GB, SECT_GB, SECT_RB};

endpackage

/* design/hbr_classify.sv */
// front two pipeline stages: min/max, gray path, saturation test and hue numerator
// depends on hbr_pkg
module hbr_classify import hbr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  red_in,
  input  logic [7:0]  green_in,
  input  logic [7:0]  blue_in,
  input  logic [7:0]  alpha_in,
  output logic        out_valid,
  input  logic        out_stall,
  output pix_t        out_pix,
  output logic        out_hue,
  output logic [7:0]  out_mx,
  output logic [7:0]  out_d,
  output logic [16:0] out_h60
);

  // stage 1 registers
  logic       s1_valid;
  pix_t       s1_pix;
  logic [7:0] s1_mx;
  logic [7:0] s1_d;
  max_sel_t   s1_sel;
  logic       s1_transp;
  logic       s1_tint;
  logic [7:0] s1_avg;
  logic [7:0] s1_nb;

  // stage 2 registers
  logic        s2_valid;
  pix_t        s2_pix;
  logic        s2_hue;
  logic [7:0]  s2_mx;
  logic [7:0]  s2_d;
  logic [16:0] s2_h60;

  logic s1_ready;
  logic s2_ready;

  // stage 1 logic
  logic [7:0] mx_next;
  logic [7:0] mn_next;
  max_sel_t   sel_next;
  logic [7:0] mrg;
  logic [8:0] sum_rg;
  logic [8:0] nb_sum;
  logic       tint_next;

  // stage 2 logic
  logic [14:0] d100;
  logic [14:0] pct_mx;
  logic        low;
  logic [10:0] n;
  logic [10:0] d2;
  logic [10:0] d4;
  logic [10:0] d6;
  pix_t        pix_next;
  logic        hue_next;

  assign s2_ready = !s2_valid || !out_stall;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_stall = !s1_ready;

  always_comb begin
    if (red_in > green_in) begin
      mx_next  = (red_in > blue_in) ? red_in : blue_in;
    end else begin
      mx_next  = (green_in > blue_in) ? green_in : blue_in;
    end
    if (red_in < green_in) begin
      mn_next = (red_in < blue_in) ? red_in : blue_in;
    end else begin
      mn_next = (green_in < blue_in) ? green_in : blue_in;
    end
    // red wins ties, then green
    if (mx_next == red_in) begin
      sel_next = MAX_RED;
    end else if (mx_next == green_in) begin
      sel_next = MAX_GREEN;
    end else begin
      sel_next = MAX_BLUE;
    end
    mrg       = (red_in < green_in) ? red_in : green_in;
    sum_rg    = {1'b0, red_in} + {1'b0, green_in};
    nb_sum    = {1'b0, sum_rg[8:1]} + {1'b0, cfg.blue_lift};
    tint_next = (blue_in > red_in) && (blue_in > green_in) &&
                ((blue_in - mrg) > cfg.blue_margin);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_pix    <= '{red: red_in, green: green_in, blue: blue_in, changed: 1'b0};
      s1_mx     <= mx_next;
      s1_d      <= mx_next - mn_next;
      s1_sel    <= sel_next;
      s1_transp <= (alpha_in == 8'd0);
      s1_tint   <= tint_next;
      s1_avg    <= sum_rg[8:1];
      s1_nb     <= nb_sum[8] ? 8'd255 : nb_sum[7:0];
    end
  end

  assign d100   = 15'(s1_d) * 15'd100;
  assign pct_mx = 15'(cfg.low_sat_percent) * 15'(s1_mx);
  assign d2     = {2'b00, s1_d, 1'b0};
  assign d4     = {1'b0, s1_d, 2'b00};
  assign d6     = d2 + d4;

  always_comb begin
    low = (s1_mx == 8'd0) ? (cfg.low_sat_percent != 7'd0) : (d100 < pct_mx);

    case (s1_sel)
      MAX_RED: begin
        if (s1_pix.green >= s1_pix.blue) begin
          n = {3'b000, s1_pix.green - s1_pix.blue};
        end else begin
          n = d6 - {3'b000, s1_pix.blue - s1_pix.green};
        end
      end
      MAX_GREEN: n = {3'b000, s1_pix.blue} + d2 - {3'b000, s1_pix.red};
      MAX_BLUE:  n = {3'b000, s1_pix.red} + d4 - {3'b000, s1_pix.green};
      default:   n = '0;
    endcase

    pix_next = s1_pix;
    hue_next = 1'b0;
    if (!s1_transp) begin
      if (low) begin
        if (s1_tint && (s1_pix.red != s1_avg || s1_pix.green != s1_avg ||
                        s1_pix.blue != s1_nb)) begin
          pix_next = '{red: s1_avg, green: s1_avg, blue: s1_nb, changed: 1'b1};
        end
      end else if (s1_d != 8'd0) begin
        hue_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      s2_pix <= pix_next;
      s2_hue <= hue_next;
      s2_mx  <= s1_mx;
      s2_d   <= s1_d;
      s2_h60 <= 17'(n) * 17'd60;
    end
  end

  assign out_valid = s2_valid;
  assign out_pix   = s2_pix;
  assign out_hue   = s2_hue;
  assign out_mx    = s2_mx;
  assign out_d     = s2_d;
  assign out_h60   = s2_h60;

  // hue path only for a colored, untouched pixel
  a_hue_has_spread: assert property (@(posedge clk) disable iff (rst)
    s2_valid && s2_hue |-> (s2_d != 8'd0) && !s2_pix.changed)
    else $error("hue path taken with zero spread or rewritten pixel");

endmodule

/* design/hbr_band.sv */
// middle two pipeline stages: band match on the hue, then coefficient products
// depends on hbr_pkg
module hbr_band import hbr_pkg::*; #(
  parameter int unsigned F = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  pix_t          in_pix,
  input  logic          in_hue,
  input  logic [7:0]    in_mx,
  input  logic [7:0]    in_d,
  input  logic [16:0]   in_h60,
  output logic          out_valid,
  input  logic          out_stall,
  output pix_t          out_pix,
  output logic          out_hit,
  output sector_t       out_sector,
  output logic [F+7:0]  out_full,
  output logic [F+7:0]  out_c,
  output logic [F+7:0]  out_dx
);

  localparam int unsigned NUM_SLOTS = 2 ** BAND_W;

  function automatic logic [F-1:0] q_vm(int unsigned i);
    logic [63:0] num;
    if (i >= NUM_BANDS) begin
      return '0;
    end
    num = 64'(BAND_VM[i]) << F;
    return F'((num + 64'd50) / 64'd100);
  endfunction

  function automatic logic [F-1:0] q_sv(int unsigned i);
    logic [63:0] num;
    if (i >= NUM_BANDS) begin
      return '0;
    end
    num = 64'(BAND_SV[i]) << F;
    return F'((num + 64'd5000) / 64'd10000);
  endfunction

  function automatic logic [F-1:0] q_svx(int unsigned i);
    logic [63:0] num;
    if (i >= NUM_BANDS) begin
      return '0;
    end
    num = 64'(BAND_SV[i] * BAND_XF[i]) << F;
    return F'((num + 64'd300000) / 64'd600000);
  endfunction

  localparam logic [F-1:0] VM_Q [NUM_SLOTS] =
    '{q_vm(0), q_vm(1), q_vm(2), q_vm(3), q_vm(4), q_vm(5), q_vm(6), q_vm(7)};
  localparam logic [F-1:0] SV_Q [NUM_SLOTS] =
    '{q_sv(0), q_sv(1), q_sv(2), q_sv(3), q_sv(4), q_sv(5), q_sv(6), q_sv(7)};
  localparam logic [F-1:0] SVX_Q [NUM_SLOTS] =
    '{q_svx(0), q_svx(1), q_svx(2), q_svx(3), q_svx(4), q_svx(5), q_svx(6), q_svx(7)};

  // stage 3 registers
  logic              s3_valid;
  pix_t              s3_pix;
  logic              s3_hit;
  logic [BAND_W-1:0] s3_band;
  sector_t           s3_sector;
  logic [7:0]        s3_mx;
  logic [7:0]        s3_d;

  // stage 4 registers
  logic         s4_valid;
  pix_t         s4_pix;
  logic         s4_hit;
  sector_t      s4_sector;
  logic [F+7:0] s4_full;
  logic [F+7:0] s4_c;
  logic [F+7:0] s4_dx;

  logic s3_ready;
  logic s4_ready;

  logic [16:0]       lo_t [NUM_BANDS];
  logic [16:0]       hi_t [NUM_BANDS];
  logic              hit_next;
  logic [BAND_W-1:0] band_next;
  sector_t           sector_next;

  assign s4_ready = !s4_valid || !out_stall;
  assign s3_ready = !s3_valid || s4_ready;
  assign in_stall = !s3_ready;

  // bands are open and disjoint, so at most one matches
  always_comb begin
    hit_next    = 1'b0;
    band_next   = '0;
    sector_next = SECT_RG;
    for (int i = 0; i < NUM_BANDS; i++) begin
      lo_t[i] = 17'(in_d) * 17'(BAND_LO[i]);
      hi_t[i] = 17'(in_d) * 17'(BAND_HI[i]);
      if (in_hue && (lo_t[i] < in_h60) && (in_h60 < hi_t[i])) begin
        hit_next    = 1'b1;
        band_next   = BAND_W'(i);
        sector_next = BAND_SECTOR[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_ready) begin
      s3_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && in_valid) begin
      s3_pix    <= in_pix;
      s3_hit    <= hit_next;
      s3_band   <= band_next;
      s3_sector <= sector_next;
      s3_mx     <= in_mx;
      s3_d      <= in_d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (s4_ready) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_ready && s3_valid) begin
      s4_pix    <= s3_pix;
      s4_hit    <= s3_hit;
      s4_sector <= s3_sector;
      s4_full   <= (F+8)'(s3_mx) * (F+8)'(VM_Q[s3_band]);
      s4_c      <= (F+8)'(s3_d) * (F+8)'(SV_Q[s3_band]);
      s4_dx     <= (F+8)'(s3_d) * (F+8)'(SVX_Q[s3_band]);
    end
  end

  assign out_valid  = s4_valid;
  assign out_pix    = s4_pix;
  assign out_hit    = s4_hit;
  assign out_sector = s4_sector;
  assign out_full   = s4_full;
  assign out_c      = s4_c;
  assign out_dx     = s4_dx;

  // a band match means nonzero max, so the value product is nonzero
  a_hit_has_value: assert property (@(posedge clk) disable iff (rst)
    s4_valid && s4_hit |-> (s4_full != '0) && !s4_pix.changed)
    else $error("band match with zero value product");

endmodule

/* design/hbr_convert.sv */
// last pipeline stage and output register: m and x terms, rounding, channel placement
// depends on hbr_pkg
module hbr_convert import hbr_pkg::*; #(
  parameter int unsigned F = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  pix_t         in_pix,
  input  logic         in_hit,
  input  sector_t      in_sector,
  input  logic [F+7:0] in_full,
  input  logic [F+7:0] in_c,
  input  logic [F+7:0] in_dx,
  output logic         out_valid,
  input  logic         out_stall,
  output pix_t         out_pix
);

  // round half up from Q.F, saturate at 255
  function automatic logic [7:0] to_byte(logic [F+8:0] v);
    logic [F+9:0] s;
    s = {1'b0, v} + ((F+10)'(1) << (F-1));
    return (s[F+9:F] > 10'd255) ? 8'd255 : s[F+7:F];
  endfunction

  logic         s5_valid;
  pix_t         s5_pix;
  logic         s5_ready;

  logic [F+7:0] m;
  logic [F+8:0] xm;
  logic [7:0]   fb;
  logic [7:0]   mb;
  logic [7:0]   xb;
  pix_t         pix_next;

  assign s5_ready = !s5_valid || !out_stall;
  assign in_stall = !s5_ready;

  always_comb begin
    m  = (in_full > in_c) ? (in_full - in_c) : '0;
    xm = {1'b0, m} + {1'b0, in_dx};
    fb = to_byte({1'b0, in_full});
    mb = to_byte({1'b0, m});
    xb = to_byte(xm);
    if (in_hit) begin
      case (in_sector)
        SECT_RG: pix_next = '{red: fb, green: xb, blue: mb, changed: 1'b1};
        SECT_GB: pix_next = '{red: mb, green: fb, blue: xb, changed: 1'b1};
        default: pix_next = '{red: fb, green: mb, blue: xb, changed: 1'b1};
      endcase
    end else begin
      pix_next = in_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else if (s5_ready) begin
      s5_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s5_ready && in_valid) begin
      s5_pix <= pix_next;
    end
  end

  assign out_valid = s5_valid;
  assign out_pix   = s5_pix;

endmodule

/* design/hsv_hue_band_pixel_recolor_core.sv */
// top level of the hue-band pixel recolor: configuration registers and pipeline
// depends on hbr_pkg, hbr_classify, hbr_band, hbr_convert
//
// Usage:
//   Pixels enter on pixel_valid/pixel_stall with red_in, green_in, blue_in and
//   alpha_in; recolored pixels leave on result_valid/result_stall with
//   red_out, green_out, blue_out and changed. A transaction completes at a
//   rising edge where valid is high and stall is low.
//   The pipeline has five register stages (extremes, hue and saturation,
//   band match, coefficient multiply, rounding and output); a pixel's
//   result is offered once it reaches the output register. One pixel is
//   taken per clock while result_stall is low; the rate is set by the
//   combinational stage handshake.
//   Each stage advances on its own when its successor has room, so bubbles
//   close up and a pixel is still accepted while a result waits downstream.
//   When result_stall stays high, the stages fill and pixel_stall rises once
//   all five hold data; nothing is dropped or repeated.
//   Synchronous reset empties the pipeline and loads the register defaults (low_sat_percent 15,
//   blue_lift 4, blue_margin 1). Registers sit at byte addresses 0, 4 and 8 on the APB port;
//   the user must see that they are written only while idle, as the block does not enforce it.
module hsv_hue_band_pixel_recolor_core import hbr_pkg::*; #(
  parameter int unsigned COEF_FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // pixel input
  input  logic        pixel_valid,
  output logic        pixel_stall,
  input  logic [7:0]  red_in,
  input  logic [7:0]  green_in,
  input  logic [7:0]  blue_in,
  input  logic [7:0]  alpha_in,
  // result output
  output logic        result_valid,
  input  logic        result_stall,
  output logic [7:0]  red_out,
  output logic [7:0]  green_out,
  output logic [7:0]  blue_out,
  output logic        changed
);

  cfg_t cfg;
  logic cfg_write;

  logic        cls_valid;
  logic        cls_stall;
  pix_t        cls_pix;
  logic        cls_hue;
  logic [7:0]  cls_mx;
  logic [7:0]  cls_d;
  logic [16:0] cls_h60;

  logic                      band_valid;
  logic                      band_stall;
  pix_t                      band_pix;
  logic                      band_hit;
  sector_t                   band_sector;
  logic [COEF_FRAC_BITS+7:0] band_full;
  logic [COEF_FRAC_BITS+7:0] band_c;
  logic [COEF_FRAC_BITS+7:0] band_dx;

  pix_t res_pix;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.low_sat_percent <= 7'd15;
      cfg.blue_lift       <= 8'd4;
      cfg.blue_margin     <= 8'd1;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        REG_LOW_SAT:     cfg.low_sat_percent <= pwdata[6:0];
        REG_BLUE_LIFT:   cfg.blue_lift       <= pwdata[7:0];
        REG_BLUE_MARGIN: cfg.blue_margin     <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_LOW_SAT:     prdata = {25'd0, cfg.low_sat_percent};
      REG_BLUE_LIFT:   prdata = {24'd0, cfg.blue_lift};
      REG_BLUE_MARGIN: prdata = {24'd0, cfg.blue_margin};
      default:         prdata = '0;
    endcase
  end

  hbr_classify u_classify (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (pixel_valid),
    .in_stall  (pixel_stall),
    .red_in    (red_in),
    .green_in  (green_in),
    .blue_in   (blue_in),
    .alpha_in  (alpha_in),
    .out_valid (cls_valid),
    .out_stall (cls_stall),
    .out_pix   (cls_pix),
    .out_hue   (cls_hue),
    .out_mx    (cls_mx),
    .out_d     (cls_d),
    .out_h60   (cls_h60)
  );

  hbr_band #(.F(COEF_FRAC_BITS)) u_band (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (cls_valid),
    .in_stall   (cls_stall),
    .in_pix     (cls_pix),
    .in_hue     (cls_hue),
    .in_mx      (cls_mx),
    .in_d       (cls_d),
    .in_h60     (cls_h60),
    .out_valid  (band_valid),
    .out_stall  (band_stall),
    .out_pix    (band_pix),
    .out_hit    (band_hit),
    .out_sector (band_sector),
    .out_full   (band_full),
    .out_c      (band_c),
    .out_dx     (band_dx)
  );

  hbr_convert #(.F(COEF_FRAC_BITS)) u_convert (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (band_valid),
    .in_stall  (band_stall),
    .in_pix    (band_pix),
    .in_hit    (band_hit),
    .in_sector (band_sector),
    .in_full   (band_full),
    .in_c      (band_c),
    .in_dx     (band_dx),
    .out_valid (result_valid),
    .out_stall (result_stall),
    .out_pix   (res_pix)
  );

  assign red_out   = res_pix.red;
  assign green_out = res_pix.green;
  assign blue_out  = res_pix.blue;
  assign changed   = res_pix.changed;

  // input backpressure only comes from a full pipeline behind a stalled output
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    pixel_stall |-> result_valid && result_stall)
    else $error("input stalled without output backpressure");

  a_reset_empties: assert property (@(posedge clk)
    !rst && $past(rst) |-> !result_valid && !pixel_stall)
    else $error("pipeline not empty after reset");

endmodule

/* sim/hbr_checker.sv */
`timescale 1ns / 100ps
// scoreboard for the hue-band pixel recolor core: follows register writes,
// predicts each accepted pixel and compares the result stream, in order
// depends on hbr_pkg
module hbr_checker import hbr_pkg::*; #(
  parameter int unsigned COEF_FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        pixel_valid,
  input  logic        pixel_stall,
  input  logic [7:0]  red_in,
  input  logic [7:0]  green_in,
  input  logic [7:0]  blue_in,
  input  logic [7:0]  alpha_in,
  input  logic        result_valid,
  input  logic        result_stall,
  input  logic [7:0]  red_out,
  input  logic [7:0]  green_out,
  input  logic [7:0]  blue_out,
  input  logic        changed,
  output int          mismatches,
  output int          in_flight
);

  // hue bands in degrees with target placement and coefficient numerators
  localparam int unsigned EDGE_LO [7] = '{0, 330, 30, 50, 80, 180, 260};
  localparam int unsigned EDGE_HI [7] = '{30, 360, 50, 80, 180, 260, 330};
  localparam int unsigned TGT_XF  [7] = '{5, 5, 22, 43, 30, 40, 50};     // /60
  localparam int unsigned TGT_SV  [7] = '{3600, 3600, 4100, 4250, 2600, 2520, 2625};
  localparam int unsigned TGT_VM  [7] = '{80, 80, 82, 85, 65, 72, 75};   // /100
  localparam sector_t TGT_SECT [7] =
    '{SECT_RB, SECT_RB, SECT_RG, SECT_RG, SECT_GB, SECT_GB, SECT_RB};

  cfg_t cfg;
  pix_t recolored_q[$];
  int   n_bad = 0;

  assign mismatches = n_bad;

  // unsigned fixed-point coefficient, rounded half up
  function automatic longint unsigned q_coef(input longint unsigned num,
                                             input longint unsigned den);
    return ((num << COEF_FRAC_BITS) + den / 2) / den;
  endfunction

  function automatic logic [7:0] to_byte(input longint unsigned v);
    longint unsigned t;
    t = (v + (64'd1 << (COEF_FRAC_BITS - 1))) >> COEF_FRAC_BITS;
    return (t > 255) ? 8'd255 : t[7:0];
  endfunction

  function automatic pix_t recolor(input logic [7:0] r, input logic [7:0] g,
                                   input logic [7:0] b, input logic [7:0] a,
                                   input cfg_t c);
    pix_t o;
    int unsigned ri, gi, bi, mx, mn, d, lo_rg, avg, nb, n, h60;
    longint unsigned vm, sv, svx, full, cm, m, xm;
    logic [7:0] fb, mb, xb;
    bit low;
    int k;
    o = '{red: r, green: g, blue: b, changed: 1'b0};
    if (a == 8'd0) return o;
    ri = 32'(r);
    gi = 32'(g);
    bi = 32'(b);
    mx = (ri > gi) ? ((ri > bi) ? ri : bi) : ((gi > bi) ? gi : bi);
    mn = (ri < gi) ? ((ri < bi) ? ri : bi) : ((gi < bi) ? gi : bi);
    d = mx - mn;
    // black counts as zero saturation
    if (mx == 0) low = (c.low_sat_percent != 0);
    else low = (d * 100 < c.low_sat_percent * mx);
    if (low) begin
      lo_rg = (ri < gi) ? ri : gi;
      if (bi > ri && bi > gi && (bi - lo_rg) > c.blue_margin) begin
        avg = (ri + gi) / 2;
        nb = avg + c.blue_lift;
        if (nb > 255) nb = 255;
        if (ri != avg || gi != avg || bi != nb)
          o = '{red: avg[7:0], green: avg[7:0], blue: nb[7:0], changed: 1'b1};
      end
      return o;
    end
    if (d == 0) return o;
    if (mx == ri) n = (gi >= bi) ? (gi - bi) : (6 * d - (bi - gi));
    else if (mx == gi) n = bi + 2 * d - ri;
    else n = ri + 4 * d - gi;
    h60 = 60 * n;
    for (k = 0; k < 7; k++) begin
      // open bands: a hue exactly on an edge matches nothing
      if (EDGE_LO[k] * d < h60 && h60 < EDGE_HI[k] * d) begin
        vm = q_coef(TGT_VM[k], 100);
        sv = q_coef(TGT_SV[k], 10000);
        svx = q_coef(TGT_SV[k] * TGT_XF[k], 600000);
        full = longint'(mx) * vm;
        cm = longint'(d) * sv;
        m = (full > cm) ? full - cm : 64'd0;
        xm = m + longint'(d) * svx;
        fb = to_byte(full);
        mb = to_byte(m);
        xb = to_byte(xm);
        case (TGT_SECT[k])
          SECT_RG: o = '{red: fb, green: xb, blue: mb, changed: 1'b1};
          SECT_GB: o = '{red: mb, green: fb, blue: xb, changed: 1'b1};
          default: o = '{red: fb, green: mb, blue: xb, changed: 1'b1};
        endcase
        return o;
      end
    end
    return o;
  endfunction

  always @(posedge clk) begin : watch
    pix_t want;
    if (rst) begin
      cfg <= '{low_sat_percent: 7'd15, blue_lift: 8'd4, blue_margin: 8'd1};
      recolored_q.delete();
      in_flight <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_LOW_SAT:     cfg.low_sat_percent <= pwdata[6:0];
          REG_BLUE_LIFT:   cfg.blue_lift <= pwdata[7:0];
          REG_BLUE_MARGIN: cfg.blue_margin <= pwdata[7:0];
          default: ;
        endcase
      end
      if (pixel_valid && !pixel_stall)
        recolored_q.push_back(recolor(red_in, green_in, blue_in, alpha_in, cfg));
      if (result_valid && !result_stall) begin
        if (recolored_q.size() == 0) begin
          if (n_bad < 10)
            $display("%0t: result transaction with no pixel pending: %s%0d %0d %0d %0b",
                     $realtime, "r g b chg = ", red_out, green_out, blue_out,
                     changed);
          n_bad = n_bad + 1;
        end else begin
          want = recolored_q.pop_front();
          if (want.red != red_out || want.green != green_out ||
              want.blue != blue_out || want.changed != changed) begin
            if (n_bad < 10)
              $display("%0t: pixel mismatch: want r=%0d g=%0d b=%0d chg=%0b, %s",
                       $realtime, want.red, want.green, want.blue, want.changed,
                       $sformatf("got r=%0d g=%0d b=%0d chg=%0b",
                                 red_out, green_out, blue_out, changed));
            n_bad = n_bad + 1;
          end
        end
      end
      in_flight <= recolored_q.size();
    end
  end

endmodule

/* sim/tb.sv */
`timescale 1ns / 100ps
// testbench top for the hue-band pixel recolor core: clock, reset, register
// programming, pixel stimulus and result-side stalls; depends on hbr_pkg, hbr_checker
module tb;
  import hbr_pkg::*;

  localparam int unsigned FRAC = 16;

  typedef enum int {FLOW, LIGHT, HEAVY} stall_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        pixel_valid = 1'b0;
  logic        pixel_stall;
  logic [7:0]  red_in = '0;
  logic [7:0]  green_in = '0;
  logic [7:0]  blue_in = '0;
  logic [7:0]  alpha_in = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [7:0]  red_out;
  logic [7:0]  green_out;
  logic [7:0]  blue_out;
  logic        changed;

  int bad_count;
  int expected_left;
  bit hold_request = 1'b0;

  hsv_hue_band_pixel_recolor_core #(.COEF_FRAC_BITS(FRAC)) DUT (.*);

  hbr_checker #(.COEF_FRAC_BITS(FRAC)) scoreboard (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .pixel_valid, .pixel_stall, .red_in, .green_in, .blue_in, .alpha_in,
    .result_valid, .result_stall, .red_out, .green_out, .blue_out, .changed,
    .mismatches(bad_count), .in_flight(expected_left)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input int unsigned sat, input int unsigned lift,
                           input int unsigned margin);
    write_reg(REG_LOW_SAT, sat);
    write_reg(REG_BLUE_LIFT, lift);
    write_reg(REG_BLUE_MARGIN, margin);
  endtask

  task automatic push_pixel(input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b, input logic [7:0] a);
    pixel_valid <= 1'b1;
    red_in <= r;
    green_in <= g;
    blue_in <= b;
    alpha_in <= a;
    @(posedge clk);
    while (pixel_stall) @(posedge clk);
  endtask

  // wait until every accepted pixel has come back
  task automatic drain();
    pixel_valid <= 1'b0;
    @(posedge clk);
    while (expected_left != 0) @(posedge clk);
  endtask

  task automatic stream_random(input int count, input bit gapless);
    int left, burst, kind, base;
    logic [7:0] r, g, b, a;
    left = count;
    while (left > 0) begin
      if (gapless) burst = left;
      else burst = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                : $urandom_range(1, 10);
      if (burst > left) burst = left;
      repeat (burst) begin
        kind = $urandom_range(0, 9);
        if (kind == 0) a = 8'd0;
        else if (kind == 1) a = 8'd255;
        else a = 8'($urandom_range(1, 255));
        if (kind <= 5) begin
          // near gray, mostly with a blue tint
          base = $urandom_range(0, 240);
          r = 8'(base + $urandom_range(0, 6));
          g = 8'(base + $urandom_range(0, 6));
          b = 8'(base + $urandom_range(0, 15));
        end else begin
          r = 8'($urandom_range(0, 255));
          g = 8'($urandom_range(0, 255));
          b = 8'($urandom_range(0, 255));
        end
        push_pixel(r, g, b, a);
      end
      left -= burst;
      if (!gapless || left == 0) begin
        pixel_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  endtask

  initial begin : result_side
    int span;
    stall_mode_t mode;
    forever begin
      mode = stall_mode_t'($urandom_range(0, 2));
      span = $urandom_range(8, 60);
      repeat (span) begin
        if (hold_request) break;
        case (mode)
          FLOW:    result_stall <= 1'b0;
          LIGHT:   result_stall <= ($urandom_range(0, 3) == 0);
          default: result_stall <= ($urandom_range(0, 3) != 0);
        endcase
        @(posedge clk);
      end
      if (hold_request) begin
        // long hold so the pipeline fills and backs up into the input
        hold_request = 1'b0;
        result_stall <= 1'b1;
        repeat (60) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // defaults: transparent, black, white, gray path, band edges, each band
    push_pixel(8'd200, 8'd10, 8'd90, 8'd0);
    push_pixel(8'd0, 8'd0, 8'd0, 8'd255);
    push_pixel(8'd255, 8'd255, 8'd255, 8'd255);
    push_pixel(8'd100, 8'd100, 8'd110, 8'd255);
    push_pixel(8'd120, 8'd120, 8'd118, 8'd1);
    push_pixel(8'd100, 8'd100, 8'd104, 8'd255);
    push_pixel(8'd101, 8'd100, 8'd102, 8'd128);
    push_pixel(8'd255, 8'd0, 8'd0, 8'd255);
    push_pixel(8'd200, 8'd100, 8'd0, 8'd255);
    push_pixel(8'd240, 8'd200, 8'd0, 8'd255);
    push_pixel(8'd160, 8'd240, 8'd0, 8'd255);
    push_pixel(8'd0, 8'd255, 8'd255, 8'd255);
    push_pixel(8'd80, 8'd0, 8'd240, 8'd255);
    push_pixel(8'd240, 8'd0, 8'd120, 8'd255);
    push_pixel(8'd255, 8'd64, 8'd0, 8'd255);
    push_pixel(8'd255, 8'd0, 8'd64, 8'd127);
    push_pixel(8'd255, 8'd200, 8'd0, 8'd255);
    push_pixel(8'd255, 8'd255, 8'd0, 8'd255);
    push_pixel(8'd0, 8'd255, 8'd0, 8'd255);
    push_pixel(8'd0, 8'd0, 8'd255, 8'd255);
    push_pixel(8'd255, 8'd0, 8'd255, 8'd255);
    push_pixel(8'd1, 8'd0, 8'd0, 8'd255);
    push_pixel(8'd2, 8'd1, 8'd0, 8'd255);
    push_pixel(8'd3, 8'd1, 8'd0, 8'd254);
    stream_random(80, 1'b0);
    drain();

    configure(0, 0, 255);
    stream_random(80, 1'b0);
    drain();

    configure(60, 255, 0);
    stream_random(80, 1'b0);
    drain();

    // above 100 percent everything takes the gray path
    configure(127, 128, 0);
    stream_random(60, 1'b0);
    drain();

    configure(100, 9, 2);
    hold_request = 1'b1;
    stream_random(40, 1'b1);
    stream_random(40, 1'b0);
    drain();

    configure($urandom_range(1, 99), $urandom_range(0, 255), $urandom_range(0, 255));
    stream_random(80, 1'b0);
    drain();

    configure($urandom_range(0, 127), $urandom_range(0, 255), $urandom_range(0, 15));
    stream_random(80, 1'b0);
    drain();

    repeat (10) @(posedge clk);
    if (bad_count == 0 && expected_left == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* hsv_hue_band_pixel_recolor_core.f */
design/hbr_pkg.sv
design/hbr_classify.sv
design/hbr_band.sv
design/hbr_convert.sv
design/hsv_hue_band_pixel_recolor_core.sv
sim/hbr_checker.sv
sim/tb.sv
